// File: hw/rtl/kdtc_pkg.sv
// Shared types and constants for the key debounce and tap counter.
// Used by the controller, the datapath and the top level.
package kdtc_pkg;

  // Field widths
  localparam int unsigned LevelW   = 6;
  localparam int unsigned KeyIdxW  = 3;
  localparam int unsigned TapW     = 2;
  localparam int unsigned DbW      = 8;
  localparam int unsigned WinW     = 10;
  localparam int unsigned MapW     = 12;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;

  // Keys that have a field in the tap map and a bit in the input word
  localparam int unsigned NumMapKeys = 6;
  // Most results one tick may deliver
  localparam int unsigned MaxResults = 12;
  localparam int unsigned CntW       = 4;

  // Saturation limits of the age counters
  localparam logic [DbW-1:0]  SettleMax = 8'd255;
  localparam logic [WinW-1:0] GapMax    = 10'd1023;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegDebounce = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWindow   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTapMap   = 2'd2;

  // Register reset values
  localparam logic [DbW-1:0]  DebounceRst = 8'd20;
  localparam logic [WinW-1:0] WindowRst   = 10'd300;
  localparam logic [MapW-1:0] TapMapRst   = 12'd1365;

  // Event kinds
  localparam logic KindRelease = 1'b0;
  localparam logic KindTaps    = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // latch the tick's key levels, rewind key counter
    logic step1;  // debounce and tap update for the current key
    logic step2;  // window timeout check for the current key
    logic flush;  // push the held event out as the tick's last one
  } kdtc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;  // output register can take a new result this cycle
    logic last_key;  // key counter sits on the highest key
  } kdtc_status_t;

endpackage

// File: hw/rtl/kdtc_ctrl.sv
// Sequencer of the key debounce and tap counter: idle, two key scans, flush.
// Depends on kdtc_pkg for the command and status structs.
module kdtc_ctrl
  import kdtc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  kdtc_status_t status_i,
  output kdtc_cmd_t    cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan1 = 2'd1;
  localparam logic [1:0] StScan2 = 2'd2;
  localparam logic [1:0] StFlush = 2'd3;

  logic [1:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StScan1;
        end
      end
      StScan1: begin
        if (status_i.out_free) begin
          cmd_o.step1 = 1'b1;
          if (status_i.last_key) state_d = StScan2;
        end
      end
      StScan2: begin
        if (status_i.out_free) begin
          cmd_o.step2 = 1'b1;
          if (status_i.last_key) state_d = StFlush;
        end
      end
      StFlush: begin
        if (status_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/kdtc_datapath.sv
// Datapath of the key debounce and tap counter: per-key state, one shared
// key update unit, config registers, held event and output register.
// Depends on kdtc_pkg.
module kdtc_datapath
  import kdtc_pkg::*;
#(
  parameter int unsigned NUM_KEYS = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kdtc_cmd_t           cmd_i,
  output kdtc_status_t        status_o,
  input  logic [LevelW-1:0]   levels_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [KeyIdxW-1:0]  out_key_o,
  output logic                out_kind_o,
  output logic [TapW-1:0]     out_taps_o,
  output logic                out_last_o
);

  localparam int unsigned KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned XW = KW + 3;

  // Config registers
  logic [DbW-1:0]  limit_q;
  logic [WinW-1:0] window_q;
  logic [MapW-1:0] map_q;

  // Per-key state
  logic [NUM_KEYS-1:0] raw_q;
  logic [NUM_KEYS-1:0] stable_q;
  logic [DbW-1:0]      settle_q [NUM_KEYS];
  logic [TapW-1:0]     pend_q   [NUM_KEYS];
  logic [WinW-1:0]     gap_q    [NUM_KEYS];

  // Tick and scan control
  logic [LevelW-1:0] lev_q;
  logic [KW-1:0]     key_q;
  logic [CntW-1:0]   cnt_q;

  // Held event, waiting to learn whether it is the tick's last
  logic               held_valid_q;
  logic [KeyIdxW-1:0] held_key_q;
  logic               held_kind_q;
  logic [TapW-1:0]    held_taps_q;

  // Output register
  logic               out_valid_q;
  logic [KeyIdxW-1:0] out_key_q;
  logic               out_kind_q;
  logic [TapW-1:0]    out_taps_q;
  logic               out_last_q;

  logic [XW-1:0]     key_ext;
  logic [LevelW-1:0] lev_shift;
  logic [MapW-1:0]   map_shift;
  logic              in_map;
  logic              r_bit;
  logic [TapW-1:0]   mx;
  logic              step;
  logic              out_free;

  logic              n_raw, n_stable;
  logic [DbW-1:0]    n_settle;
  logic [WinW-1:0]   n_gap;
  logic [TapW-1:0]   n_pend, p_inc;
  logic              ev_valid, ev_kind;
  logic [TapW-1:0]   ev_taps;
  logic              push;

  assign step     = cmd_i.step1 | cmd_i.step2;
  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.out_free = out_free;
  assign status_o.last_key = (key_q == KW'(NUM_KEYS - 1));

  // Key-dependent selects: raw level and maximum taps
  assign key_ext   = XW'(key_q);
  assign in_map    = key_ext < XW'(NumMapKeys);
  assign lev_shift = lev_q >> key_q;
  assign map_shift = map_q >> {key_q, 1'b0};
  assign r_bit     = in_map ? lev_shift[0] : 1'b0;
  assign mx        = (in_map && map_shift[TapW-1:0] != '0) ? map_shift[TapW-1:0] : 2'd1;
  assign p_inc     = pend_q[key_q] + 2'd1;

  // Shared key update unit
  always_comb begin
    n_raw    = raw_q[key_q];
    n_stable = stable_q[key_q];
    n_settle = settle_q[key_q];
    n_gap    = gap_q[key_q];
    n_pend   = pend_q[key_q];
    ev_valid = 1'b0;
    ev_kind  = KindTaps;
    ev_taps  = '0;
    if (cmd_i.step1) begin
      // Advance the ages, saturating
      if (n_settle < SettleMax) n_settle = n_settle + 8'd1;
      if (n_gap < GapMax) n_gap = n_gap + 10'd1;
      // Restart settling on a raw change
      if (r_bit != n_raw) begin
        n_settle = '0;
        n_raw    = r_bit;
      end
      // Accept a settled level
      if (n_settle > limit_q && r_bit != n_stable) begin
        n_stable = r_bit;
        if (!r_bit) begin
          if (n_pend == '0 && mx == 2'd1) begin
            ev_valid = 1'b1;
            ev_taps  = 2'd1;
          end else begin
            n_pend = p_inc;
            n_gap  = '0;
            if (p_inc >= mx) begin
              ev_valid = 1'b1;
              ev_taps  = (p_inc > mx) ? mx : p_inc;
              n_pend   = '0;
            end
          end
        end else begin
          ev_valid = 1'b1;
          ev_kind  = KindRelease;
        end
      end
    end else if (cmd_i.step2) begin
      // Resolve a sequence whose gap ran past the window
      if (n_pend != '0 && n_gap > window_q) begin
        ev_valid = 1'b1;
        ev_taps  = (n_pend > mx) ? mx : n_pend;
        n_pend   = '0;
      end
    end
  end

  assign push = ev_valid && (cnt_q < CntW'(MaxResults));

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= DebounceRst;
      window_q <= WindowRst;
      map_q    <= TapMapRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegDebounce: limit_q  <= cfg_data_i[DbW-1:0];
        RegWindow:   window_q <= cfg_data_i[WinW-1:0];
        RegTapMap:   map_q    <= cfg_data_i[MapW-1:0];
        default: ;
      endcase
    end
  end

  // Per-key state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= '1;
      stable_q <= '1;
      for (int i = 0; i < NUM_KEYS; i++) begin
        settle_q[i] <= '0;
        pend_q[i]   <= '0;
        gap_q[i]    <= '0;
      end
    end else if (step) begin
      raw_q[key_q]    <= n_raw;
      stable_q[key_q] <= n_stable;
      settle_q[key_q] <= n_settle;
      gap_q[key_q]    <= n_gap;
      pend_q[key_q]   <= n_pend;
    end
  end

  // Key counter and result count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        key_q <= '0;
        cnt_q <= '0;
      end else begin
        if (step) key_q <= status_o.last_key ? '0 : key_q + KW'(1);
        if (push) cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  // Latch the tick's levels
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) lev_q <= levels_i;
  end

  // Held event and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_ready_i) out_valid_q <= 1'b0;
      if (push) begin
        held_valid_q <= 1'b1;
        if (held_valid_q) out_valid_q <= 1'b1;
      end else if (cmd_i.flush && held_valid_q) begin
        held_valid_q <= 1'b0;
        out_valid_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      held_key_q  <= key_ext[KeyIdxW-1:0];
      held_kind_q <= ev_kind;
      held_taps_q <= ev_taps;
    end
    if ((push || cmd_i.flush) && held_valid_q && out_free) begin
      out_key_q  <= held_key_q;
      out_kind_q <= held_kind_q;
      out_taps_q <= held_taps_q;
      out_last_q <= cmd_i.flush;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_key_o   = out_key_q;
  assign out_kind_o  = out_kind_q;
  assign out_taps_o  = out_taps_q;
  assign out_last_o  = out_last_q;

endmodule

// File: hw/rtl/key_debounce_tap_counter_core.sv
// Key debounce and multi-tap counter, top level.
//
// Usage:
//   Slave stream: one request per millisecond tick, tdata[5:0] carries the
//   raw key levels (1 released, 0 pressed). Config channel: cfg_index_i
//   selects debounce limit (0), tap window (1) or tap map (2); write only
//   while the block is idle. Master stream: zero or more events per tick,
//   tdata = key index and tap count, tuser = event kind, tlast on the final
//   event of the tick.
// Timing:
//   One shared key update unit visits every key twice, once for debounce
//   and taps and once for window timeouts, then the last event is flushed.
//   Each step of a tick waits while the receiver stalls with an event in
//   the output register, and a new tick is accepted only after the flush.
//   Each event waits in a holding register until the tick's next event or
//   the flush step moves it out.
// Reset:
//   Keys read released with zero ages and no pending taps, registers take
//   their defaults (20, 300, 0x555), the output stream goes empty.
//   A stalled receiver halts the key scan; no event is lost.
module key_debounce_tap_counter_core
  import kdtc_pkg::*;
#(
  parameter int unsigned NUM_KEYS = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Tick input
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [5:0] key_levels
  // Event output
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [2:0] key_index, [4:3] tap_total
  output logic                m_axis_tuser,   // [0] event_kind
  output logic                m_axis_tlast,   // last_event
  // Register writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  kdtc_cmd_t          cmd;
  kdtc_status_t       status;
  logic [KeyIdxW-1:0] out_key;
  logic [TapW-1:0]    out_taps;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  kdtc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Key state and event path
  kdtc_datapath #(
    .NUM_KEYS (NUM_KEYS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .levels_i    (s_axis_tdata[LevelW-1:0]),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_key_o   (out_key),
    .out_kind_o  (m_axis_tuser),
    .out_taps_o  (out_taps),
    .out_last_o  (m_axis_tlast)
  );

  // Pack the event word
  assign m_axis_tdata = {3'b000, out_taps, out_key};

endmodule
